FILE: sv/assert_macros.svh
// assertion macros used by the forwarding engine back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: sv/ipv4fe_pkg.sv
// shared types and constants of the forwarding engine
`default_nettype none
package ipv4fe_pkg;
   localparam int TABLE_DEPTH_DEF = 64;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] CMD_HEADER = 2'd0;
   localparam logic [1:0] CMD_ADD    = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   localparam logic [2:0] VERDICT_LOCAL   = 3'd0;
   localparam logic [2:0] VERDICT_FORWARD = 3'd1;
   localparam logic [2:0] VERDICT_EXPIRED = 3'd2;
   localparam logic [2:0] VERDICT_NOROUTE = 3'd3;
   localparam logic [2:0] VERDICT_ADDED   = 3'd4;
   localparam logic [2:0] VERDICT_DUP     = 3'd5;
   localparam logic [2:0] VERDICT_FULL    = 3'd6;

   localparam logic [4:0] IDX_IHL   = 5'd0;
   localparam logic [4:0] IDX_TTL   = 5'd4;
   localparam logic [4:0] IDX_CKSUM = 5'd5;
   localparam logic [4:0] IDX_DST_HI = 5'd8;
   localparam logic [4:0] IDX_DST_LO = 5'd9;
   localparam logic [4:0] IDX_MAX   = 5'd31;

   typedef enum logic [1:0] {
      JOB_LOOKUP,
      JOB_ADD,
      JOB_CLEAR
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [31:0]  dest;
      logic [31:0]  hop;
      logic [7:0]   ttl;
      logic [15:0]  cksum;
   } job_type;
endpackage
`default_nettype wire

FILE: sv/ipv4_forward_engine_unit.sv
// In the back end a route add or a packet verdict searches the route table entry by entry;
// local, ttl-expired and empty-table cases skip the search. Each table entry searched takes a
// registered ram read, then a compare. Clear gives no result. Header halfwords that are not last
// push no job; a 2-entry job queue and an output register
// let the front accept while the back searches. Reset is synchronous, active high; it empties
// the route table through its fill count and clears all header and handshake state.
`default_nettype none
module ipv4_forward_engine_unit #(
   parameter int TABLE_DEPTH = ipv4fe_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [1:0]  req_command,
   input  wire logic [31:0] req_route_dest,
   input  wire logic [31:0] req_route_next_hop,
   input  wire logic [15:0] req_header_halfword,
   input  wire logic        req_header_last,
   output logic             empty,
   input  wire logic        pop,
   output logic [2:0]       rsp_verdict,
   output logic [31:0]      rsp_next_hop,
   output logic [7:0]       rsp_new_ttl,
   output logic [15:0]      rsp_new_checksum,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);
   logic                local_address_ff;
   logic [31:0]         local_addr_ff;
   ipv4fe_pkg::job_type front_job;
   ipv4fe_pkg::job_type q_head;
   logic                job_push;
   logic                q_pop;
   logic                q_empty;
   logic                accept;

   assign accept = push && !full;

   // local address register
   always_ff @(posedge clock) begin
      if (reset) begin
         local_addr_ff    <= '0;
         local_address_ff <= 1'b0;
      end else if (csr_wr_en) begin
         local_addr_ff    <= csr_wr_data;
         local_address_ff <= 1'b1;
      end
   end

   ipv4fe_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .command        (req_command),
      .route_dest     (req_route_dest),
      .route_next_hop (req_route_next_hop),
      .header_halfword(req_header_halfword),
      .header_last    (req_header_last),
      .job_push       (job_push),
      .job            (front_job)
   );

   ipv4fe_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (job_push),
      .push_job(front_job),
      .pop     (q_pop),
      .head    (q_head),
      .full    (full),
      .empty   (q_empty)
   );

   ipv4fe_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock           (clock),
      .reset           (reset),
      .local_address   (local_address_ff ? local_addr_ff : 32'd0),
      .q_head          (q_head),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .rsp_pop         (pop),
      .rsp_empty       (empty),
      .rsp_verdict     (rsp_verdict),
      .rsp_next_hop    (rsp_next_hop),
      .rsp_new_ttl     (rsp_new_ttl),
      .rsp_new_checksum(rsp_new_checksum)
   );
endmodule
`default_nettype wire

FILE: sv/ipv4fe_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module ipv4fe_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0]      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

FILE: sv/ipv4fe_front.sv
// front end: accepts items, parses header halfwords, builds jobs
`default_nettype none
module ipv4fe_front (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic [1:0]  command,
   input  wire logic [31:0] route_dest,
   input  wire logic [31:0] route_next_hop,
   input  wire logic [15:0] header_halfword,
   input  wire logic        header_last,
   output logic             job_push,
   output ipv4fe_pkg::job_type job
);
   logic [4:0]  idx_ff, idx_in;
   logic [3:0]  hw_ff, hw_in;
   logic [7:0]  ttl_ff, ttl_in;
   logic [7:0]  proto_ff, proto_in;
   logic [31:0] dest_ff, dest_in;
   logic [15:0] sum_ff, sum_in;
   logic [15:0] term;
   logic [16:0] sum_wide;
   logic [15:0] sum_fold;
   logic        is_hdr;

   // header field capture and running checksum
   always_comb begin
      is_hdr   = accept && (command == ipv4fe_pkg::CMD_HEADER);
      hw_in    = (idx_ff == ipv4fe_pkg::IDX_IHL) ? header_halfword[11:8] : hw_ff;
      ttl_in   = (idx_ff == ipv4fe_pkg::IDX_TTL) ? header_halfword[15:8] : ttl_ff;
      proto_in = (idx_ff == ipv4fe_pkg::IDX_TTL) ? header_halfword[7:0] : proto_ff;
      dest_in  = dest_ff;
      if (idx_ff == ipv4fe_pkg::IDX_DST_HI) begin
         dest_in = {header_halfword, dest_ff[15:0]};
      end
      if (idx_ff == ipv4fe_pkg::IDX_DST_LO) begin
         dest_in = {dest_ff[31:16], header_halfword};
      end
      term     = (idx_ff == ipv4fe_pkg::IDX_TTL) ? {ttl_in - 8'd1, proto_in} : header_halfword;
      sum_wide = {1'b0, sum_ff} + {1'b0, term};
      sum_fold = sum_wide[15:0] + {15'd0, sum_wide[16]};
      sum_in   = sum_ff;
      if ((idx_ff < {hw_in, 1'b0}) && (idx_ff != ipv4fe_pkg::IDX_CKSUM)) begin
         sum_in = sum_fold;
      end
      idx_in = (idx_ff == ipv4fe_pkg::IDX_MAX) ? idx_ff : idx_ff + 5'd1;
   end

   // job built from the current item
   always_comb begin
      job_push = accept && ((command == ipv4fe_pkg::CMD_ADD) ||
                 (command == ipv4fe_pkg::CMD_CLEAR) || (is_hdr && header_last));
      job.kind  = ipv4fe_pkg::JOB_LOOKUP;
      job.dest  = dest_in;
      job.hop   = route_next_hop;
      job.ttl   = ttl_in;
      job.cksum = ~sum_in;
      case (command)
         ipv4fe_pkg::CMD_ADD: begin
            job.kind = ipv4fe_pkg::JOB_ADD;
            job.dest = route_dest;
         end
         ipv4fe_pkg::CMD_CLEAR: begin
            job.kind = ipv4fe_pkg::JOB_CLEAR;
         end
         default: begin
            job.kind = ipv4fe_pkg::JOB_LOOKUP;
         end
      endcase
   end

   // header state, cleared after the last halfword
   always_ff @(posedge clock) begin
      if (reset || (is_hdr && header_last)) begin
         idx_ff   <= '0;
         hw_ff    <= '0;
         ttl_ff   <= '0;
         proto_ff <= '0;
         dest_ff  <= '0;
         sum_ff   <= '0;
      end else if (is_hdr) begin
         idx_ff   <= idx_in;
         hw_ff    <= hw_in;
         ttl_ff   <= ttl_in;
         proto_ff <= proto_in;
         dest_ff  <= dest_in;
         sum_ff   <= sum_in;
      end
   end
endmodule
`default_nettype wire

FILE: sv/ipv4fe_queue.sv
// short job queue between front and back
`default_nettype none
module ipv4fe_queue (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire ipv4fe_pkg::job_type push_job,
   input  wire logic   pop,
   output ipv4fe_pkg::job_type head,
   output logic        full,
   output logic        empty
);
   localparam int PW = $clog2(ipv4fe_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(ipv4fe_pkg::QUEUE_DEPTH + 1);

   ipv4fe_pkg::job_type q_ff [ipv4fe_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] cnt_ff;

   assign full  = (cnt_ff == CW'(ipv4fe_pkg::QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = q_ff[rd_ptr_ff];

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_job;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         cnt_ff <= cnt_ff + CW'(push) - CW'(pop);
      end
   end
endmodule
`default_nettype wire

FILE: sv/ipv4fe_back.sv
// back end: route table search, insert, clear and verdicts
`default_nettype none
`include "assert_macros.svh"
module ipv4fe_back #(
   parameter int TABLE_DEPTH = ipv4fe_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [31:0] local_address,
   input  wire ipv4fe_pkg::job_type q_head,
   input  wire logic        q_empty,
   output logic             q_pop,
   input  wire logic        rsp_pop,
   output logic             rsp_empty,
   output logic [2:0]       rsp_verdict,
   output logic [31:0]      rsp_next_hop,
   output logic [7:0]       rsp_new_ttl,
   output logic [15:0]      rsp_new_checksum
);
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_OUT
   } state_type;

   state_type            state_ff;
   ipv4fe_pkg::job_type  job_ff;
   ipv4fe_pkg::job_type  cur;
   logic [CNT_W-1:0]     count_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [2:0]           res_verdict_ff;
   logic [31:0]          res_hop_ff;
   logic [7:0]           res_ttl_ff;
   logic [15:0]          res_cksum_ff;
   logic                 rsp_vld_ff;
   logic [2:0]           rsp_verdict_ff;
   logic [31:0]          rsp_hop_ff;
   logic [7:0]           rsp_ttl_ff;
   logic [15:0]          rsp_cksum_ff;
   logic [63:0]          rd_data;
   logic                 hit;
   logic                 at_end;
   logic                 miss;
   logic                 ram_wr_en;
   logic [2:0]           miss_verdict;
   logic                 out_load;

   ipv4fe_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(count_ff[IDX_W-1:0]),
      .wr_data({cur.dest, cur.hop}),
      .rd_addr(idx_ff),
      .rd_data(rd_data)
   );

   // search control and insert on a miss
   always_comb begin
      cur    = (state_ff == ST_IDLE) ? q_head : job_ff;
      q_pop  = (state_ff == ST_IDLE) && !q_empty;
      hit    = (state_ff == ST_CMP) && (rd_data[63:32] == job_ff.dest);
      at_end = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
      miss   = ((state_ff == ST_CMP) && !hit && at_end) ||
               (q_pop && (count_ff == '0) &&
                ((q_head.kind == ipv4fe_pkg::JOB_ADD) ||
                 ((q_head.kind == ipv4fe_pkg::JOB_LOOKUP) &&
                  (q_head.dest != local_address) && (q_head.ttl != 8'd0))));
      ram_wr_en = miss && (cur.kind == ipv4fe_pkg::JOB_ADD) &&
                  (count_ff != CNT_W'(TABLE_DEPTH));
      if (cur.kind == ipv4fe_pkg::JOB_ADD) begin
         miss_verdict = ram_wr_en ? ipv4fe_pkg::VERDICT_ADDED : ipv4fe_pkg::VERDICT_FULL;
      end else begin
         miss_verdict = ipv4fe_pkg::VERDICT_NOROUTE;
      end
      out_load = (state_ff == ST_OUT) && (!rsp_vld_ff || rsp_pop);
   end

   // sequencer with result and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         idx_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (out_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_vld_ff <= 1'b0;
         end
         if (ram_wr_en) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         case (state_ff)
            ST_IDLE: begin
               idx_ff <= '0;
               if (q_pop) begin
                  job_ff       <= q_head;
                  res_hop_ff   <= '0;
                  res_ttl_ff   <= '0;
                  res_cksum_ff <= '0;
                  if (q_head.kind == ipv4fe_pkg::JOB_CLEAR) begin
                     count_ff <= '0;
                  end else if (q_head.kind == ipv4fe_pkg::JOB_LOOKUP &&
                               q_head.dest == local_address) begin
                     res_verdict_ff <= ipv4fe_pkg::VERDICT_LOCAL;
                     state_ff       <= ST_OUT;
                  end else if (q_head.kind == ipv4fe_pkg::JOB_LOOKUP &&
                               q_head.ttl == 8'd0) begin
                     res_verdict_ff <= ipv4fe_pkg::VERDICT_EXPIRED;
                     state_ff       <= ST_OUT;
                  end else if (miss) begin
                     res_verdict_ff <= miss_verdict;
                     state_ff       <= ST_OUT;
                  end else begin
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_READ: begin
               state_ff <= ST_CMP;
            end
            ST_CMP: begin
               if (hit && (job_ff.kind != ipv4fe_pkg::JOB_ADD)) begin
                  res_verdict_ff <= ipv4fe_pkg::VERDICT_FORWARD;
                  res_hop_ff     <= rd_data[31:0];
                  res_ttl_ff     <= job_ff.ttl - 8'd1;
                  res_cksum_ff   <= job_ff.cksum;
                  state_ff       <= ST_OUT;
               end else if (hit || miss) begin
                  res_verdict_ff <= hit ? ipv4fe_pkg::VERDICT_DUP : miss_verdict;
                  res_hop_ff     <= '0;
                  res_ttl_ff     <= '0;
                  res_cksum_ff   <= '0;
                  state_ff       <= ST_OUT;
               end else begin
                  idx_ff   <= idx_ff + IDX_W'(1);
                  state_ff <= ST_READ;
               end
            end
            ST_OUT: begin
               if (out_load) begin
                  rsp_verdict_ff <= res_verdict_ff;
                  rsp_hop_ff     <= res_hop_ff;
                  rsp_ttl_ff     <= res_ttl_ff;
                  rsp_cksum_ff   <= res_cksum_ff;
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_empty        = !rsp_vld_ff;
   assign rsp_verdict      = rsp_verdict_ff;
   assign rsp_next_hop     = rsp_hop_ff;
   assign rsp_new_ttl      = rsp_ttl_ff;
   assign rsp_new_checksum = rsp_cksum_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(TABLE_DEPTH))
   `ASSERT_ALWAYS(a_cmp_in_table, clock, reset, (state_ff != ST_CMP) || (CNT_W'(idx_ff) < count_ff))
   `ASSERT_NEXT(a_insert_grows, clock, reset, ram_wr_en, count_ff == $past(count_ff) + CNT_W'(1))
endmodule
`default_nettype wire

FILE: verif/ipv4_forward_engine_unit_tb.sv
// self-checking testbench of the ipv4 forwarding engine: route commands and header streams
`default_nettype none
module ipv4_forward_engine_unit_tb;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int ROUTES = 64;
   localparam int DRAIN_CYCLES = 300;
   localparam int CYCLE_LIMIT = 1500000;

   typedef struct {
      logic [1:0]  cmd;
      logic [31:0] dest;
      logic [31:0] hop;
      logic [15:0] halfword;
      logic        last;
   } fwd_request_type;

   typedef struct {
      logic [2:0]  verdict;
      logic [31:0] hop;
      logic [7:0]  ttl;
      logic [15:0] cksum;
   } verdict_rec_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [1:0]  req_command = CMD_UNUSED;
   logic [31:0] req_route_dest = '0;
   logic [31:0] req_route_next_hop = '0;
   logic [15:0] req_header_halfword = '0;
   logic        req_header_last = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic [2:0]  rsp_verdict;
   logic [31:0] rsp_next_hop;
   logic [7:0]  rsp_new_ttl;
   logic [15:0] rsp_new_checksum;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   ipv4_forward_engine_unit dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_command(req_command), .req_route_dest(req_route_dest),
      .req_route_next_hop(req_route_next_hop), .req_header_halfword(req_header_halfword),
      .req_header_last(req_header_last),
      .empty(empty), .pop(pop),
      .rsp_verdict(rsp_verdict), .rsp_next_hop(rsp_next_hop),
      .rsp_new_ttl(rsp_new_ttl), .rsp_new_checksum(rsp_new_checksum),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // stimulus and expectation stores
   fwd_request_type pending_items[$];
   verdict_rec_type expected_verdicts[$];
   logic [31:0]     known_dests[$];

   // mirrored engine state
   logic [31:0] own_address = '0;
   logic [31:0] rt_dest [ROUTES];
   logic [31:0] rt_hop [ROUTES];
   logic        rt_valid [ROUTES];
   int          rt_count = 0;
   int          hdr_pos = 0;
   int          hdr_ihl = 0;
   logic [7:0]  hdr_ttl = '0;
   logic [7:0]  hdr_proto = '0;
   logic [31:0] hdr_dst = '0;
   logic [15:0] hdr_sum = '0;

   int  cycles = 0;
   int  mismatches = 0;
   int  items_queued = 0;
   int  verdict_seen [8];
   bit  calm = 1'b0;
   bit  in_taken = 1'b0;
   bit  out_taken = 1'b0;
   int  in_gap = 0;
   int  out_gap = 0;

   initial forever #1 clock = ~clock;

   // first matching valid entry wins
   function automatic bit route_find(input logic [31:0] d, output logic [31:0] h);
      h = '0;
      for (int i = 0; i < ROUTES; i++)
         if (rt_valid[i] && rt_dest[i] == d) begin
            h = rt_hop[i];
            return 1'b1;
         end
      return 1'b0;
   endfunction

   // advance the mirrored state by one accepted item, queue any verdict
   task automatic forecast_verdict(input fwd_request_type it);
      verdict_rec_type v;
      logic [31:0] h;
      logic [16:0] s;
      logic [15:0] term;
      v = '{verdict: ipv4fe_pkg::VERDICT_ADDED, hop: '0, ttl: '0, cksum: '0};
      case (it.cmd)
         ipv4fe_pkg::CMD_ADD: begin
            if (route_find(it.dest, h)) v.verdict = ipv4fe_pkg::VERDICT_DUP;
            else if (rt_count >= ROUTES) v.verdict = ipv4fe_pkg::VERDICT_FULL;
            else begin
               rt_dest[rt_count] = it.dest;
               rt_hop[rt_count] = it.hop;
               rt_valid[rt_count] = 1'b1;
               rt_count++;
            end
            expected_verdicts.push_back(v);
         end
         ipv4fe_pkg::CMD_CLEAR: begin
            for (int i = 0; i < ROUTES; i++) rt_valid[i] = 1'b0;
            rt_count = 0;
         end
         ipv4fe_pkg::CMD_HEADER: begin
            if (hdr_pos == ipv4fe_pkg::IDX_IHL) hdr_ihl = int'(it.halfword[11:8]);
            if (hdr_pos == ipv4fe_pkg::IDX_TTL) begin
               hdr_ttl = it.halfword[15:8];
               hdr_proto = it.halfword[7:0];
            end
            if (hdr_pos == ipv4fe_pkg::IDX_DST_HI) hdr_dst[31:16] = it.halfword;
            if (hdr_pos == ipv4fe_pkg::IDX_DST_LO) hdr_dst[15:0] = it.halfword;
            if (hdr_pos < hdr_ihl * 2 && hdr_pos != ipv4fe_pkg::IDX_CKSUM) begin
               term = (hdr_pos == ipv4fe_pkg::IDX_TTL) ? {hdr_ttl - 8'd1, hdr_proto}
                                                       : it.halfword;
               s = {1'b0, hdr_sum} + {1'b0, term};
               hdr_sum = s[15:0] + {15'd0, s[16]};
            end
            if (hdr_pos < ipv4fe_pkg::IDX_MAX) hdr_pos++;
            if (it.last) begin
               if (hdr_dst == own_address) v.verdict = ipv4fe_pkg::VERDICT_LOCAL;
               else if (hdr_ttl == 8'd0) v.verdict = ipv4fe_pkg::VERDICT_EXPIRED;
               else if (route_find(hdr_dst, h)) begin
                  v.verdict = ipv4fe_pkg::VERDICT_FORWARD;
                  v.hop = h;
                  v.ttl = hdr_ttl - 8'd1;
                  v.cksum = ~hdr_sum;
               end else v.verdict = ipv4fe_pkg::VERDICT_NOROUTE;
               expected_verdicts.push_back(v);
               hdr_pos = 0; hdr_ihl = 0; hdr_ttl = '0; hdr_proto = '0;
               hdr_dst = '0; hdr_sum = '0;
            end
         end
         default: ;
      endcase
   endtask

   // input driver: changes at the falling edge
   always @(negedge clock) begin
      fwd_request_type it;
      if (!reset && (!push || in_taken)) begin
         if (in_gap > 0) begin
            push <= 1'b0;
            in_gap--;
         end else if (pending_items.size() > 0) begin
            it = pending_items.pop_front();
            req_command <= it.cmd;
            req_route_dest <= it.dest;
            req_route_next_hop <= it.hop;
            req_header_halfword <= it.halfword;
            req_header_last <= it.last;
            push <= 1'b1;
            in_gap = calm ? 0 : $urandom_range(0, 7);
         end else push <= 1'b0;
      end
      // result side stalls
      if (!reset && (!pop || out_taken)) begin
         if (out_gap > 0) begin
            pop <= 1'b0;
            out_gap--;
         end else begin
            pop <= 1'b1;
            out_gap = calm ? 0 : $urandom_range(0, 7);
         end
      end
   end

   // monitor: samples at the rising edge
   always @(posedge clock) begin
      verdict_rec_type e;
      fwd_request_type it;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
      in_taken <= !reset && push && !full;
      out_taken <= !reset && pop && !empty;
      if (!reset && push && !full) begin
         it = '{cmd: req_command, dest: req_route_dest, hop: req_route_next_hop,
                halfword: req_header_halfword, last: req_header_last};
         forecast_verdict(it);
      end
      if (!reset && pop && !empty) begin
         verdict_seen[rsp_verdict]++;
         if (expected_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: verdict %0d hop %h", rsp_verdict, rsp_next_hop);
         end else begin
            e = expected_verdicts.pop_front();
            if (e.verdict !== rsp_verdict || e.hop !== rsp_next_hop ||
                e.ttl !== rsp_new_ttl || e.cksum !== rsp_new_checksum) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp v%0d hop %h ttl %h ck %h, got v%0d hop %h ttl %h ck %h",
                           e.verdict, e.hop, e.ttl, e.cksum, rsp_verdict, rsp_next_hop,
                           rsp_new_ttl, rsp_new_checksum);
            end
         end
      end
   end

   task automatic queue_item(input logic [1:0] c, input logic [31:0] d, input logic [31:0] h,
                             input logic [15:0] w, input logic l);
      pending_items.push_back('{cmd: c, dest: d, hop: h, halfword: w, last: l});
      items_queued++;
   endtask

   task automatic queue_route(input logic [31:0] d, input logic [31:0] h);
      queue_item(ipv4fe_pkg::CMD_ADD, d, h, 16'($urandom), 1'($urandom_range(0, 1)));
      known_dests.push_back(d);
   endtask

   task automatic queue_clear();
      queue_item(ipv4fe_pkg::CMD_CLEAR, $urandom, $urandom, 16'($urandom),
                 1'($urandom_range(0, 1)));
      known_dests.delete();
   endtask

   // one header stream, nwords halfwords long, well-formed fields up front
   task automatic queue_packet(input logic [31:0] d, input logic [7:0] ttl,
                               input logic [3:0] ihl, input int nwords);
      logic [15:0] w;
      for (int i = 0; i < nwords; i++) begin
         w = 16'($urandom);
         if (i == ipv4fe_pkg::IDX_IHL) w[15:8] = {4'd4, ihl};
         if (i == ipv4fe_pkg::IDX_TTL) w[15:8] = ttl;
         if (i == ipv4fe_pkg::IDX_DST_HI) w = d[31:16];
         if (i == ipv4fe_pkg::IDX_DST_LO) w = d[15:0];
         queue_item(ipv4fe_pkg::CMD_HEADER, $urandom, $urandom, w, i == nwords - 1);
      end
   endtask

   function automatic logic [31:0] pick_dest();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55 && known_dests.size() > 0)
         return known_dests[$urandom_range(0, known_dests.size() - 1)];
      if (r < 70) return own_address;
      return $urandom;
   endfunction

   // mostly well-formed packets with random content, route adds and clears, some broken streams and noise
   task automatic queue_random(input int n);
      int stop, r, ihl, nw;
      logic [7:0] ttl;
      stop = items_queued + n;
      while (items_queued < stop) begin
         r = $urandom_range(0, 99);
         if (r < 15) begin
            if (known_dests.size() > 0 && $urandom_range(0, 3) == 0)
               queue_item(ipv4fe_pkg::CMD_ADD,
                          known_dests[$urandom_range(0, known_dests.size() - 1)],
                          $urandom, 16'($urandom), 1'b0);
            else queue_route($urandom, $urandom);
         end else if (r < 17) queue_clear();
         else if (r < 20) queue_item(CMD_UNUSED, $urandom, $urandom, 16'($urandom), 1'b1);
         else if (r < 28)
            queue_item(ipv4fe_pkg::CMD_HEADER, $urandom, $urandom, 16'($urandom), 1'b0);
         else begin
            r = $urandom_range(0, 19);
            ttl = (r == 0) ? 8'd0 : (r == 1) ? 8'd1 : (r == 2) ? 8'hff : 8'($urandom);
            ihl = $urandom_range(5, 15);
            nw = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : ihl * 2;
            if ($urandom_range(0, 19) == 0) ihl = $urandom_range(0, 4);
            queue_packet(pick_dest(), ttl, 4'(ihl), nw);
         end
      end
   endtask

   // wait for the engine to drain; set_local then writes the local address
   task automatic drain_engine();
      while (pending_items.size() > 0 || push || expected_verdicts.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_local(input logic [31:0] a);
      drain_engine();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= a;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      own_address = a;
   endtask

   // test sequence
   initial begin
      for (int i = 0; i < ROUTES; i++) begin
         rt_valid[i] = 1'b0; rt_dest[i] = '0; rt_hop[i] = '0;
      end
      for (int i = 0; i < 8; i++) verdict_seen[i] = 0;
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: ignored command, dup, forward, expired, no route, local, short, clear
      calm = 1'b1;
      queue_item(CMD_UNUSED, '1, '1, '1, 1'b1);
      queue_route(32'hffffffff, 32'hffffffff);
      queue_route(32'h0a000001, 32'hc0a80001);
      queue_item(ipv4fe_pkg::CMD_ADD, 32'h0a000001, 32'h12345678, '0, 1'b0);
      queue_packet(32'h0a000001, 8'hff, 4'd5, 10);
      queue_packet(32'hffffffff, 8'd1, 4'd15, 30);
      queue_packet(32'h0a000001, 8'd0, 4'd5, 10);
      queue_packet(32'h0b000002, 8'd64, 4'd5, 10);
      queue_packet(32'h00000000, 8'd64, 4'd5, 10);
      queue_item(ipv4fe_pkg::CMD_HEADER, '0, '0, 16'hffff, 1'b1);
      queue_packet(32'h0a000001, 8'd9, 4'd0, 40);
      queue_clear();
      queue_packet(32'h0a000001, 8'd9, 4'd5, 10);
      queue_route(32'h00000000, 32'h00000000);

      set_local(32'hffffffff);
      calm = 1'b0;
      queue_route($urandom, $urandom);
      queue_packet(32'hffffffff, 8'd3, 4'd5, 10);
      queue_random(80);

      // overfill the route table
      set_local($urandom);
      queue_clear();
      for (int i = 0; i < ROUTES + 6; i++) queue_route($urandom, $urandom);
      queue_random(60);

      set_local(32'h00000000);
      calm = 1'b1;
      queue_random(60);
      calm = 1'b0;
      queue_random(60);

      set_local($urandom);
      queue_random(90);

      drain_engine();
      if (expected_verdicts.size() != 0) mismatches++;
      $display("covered %0d items over %0d cycles: local %0d, forward %0d, expired %0d",
               items_queued, cycles, verdict_seen[ipv4fe_pkg::VERDICT_LOCAL],
               verdict_seen[ipv4fe_pkg::VERDICT_FORWARD],
               verdict_seen[ipv4fe_pkg::VERDICT_EXPIRED]);
      $display("no route %0d, added %0d, duplicate %0d, table full %0d, mismatches %0d",
               verdict_seen[ipv4fe_pkg::VERDICT_NOROUTE],
               verdict_seen[ipv4fe_pkg::VERDICT_ADDED],
               verdict_seen[ipv4fe_pkg::VERDICT_DUP],
               verdict_seen[ipv4fe_pkg::VERDICT_FULL], mismatches);
      if (mismatches == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+sv
sv/ipv4fe_pkg.sv
sv/ipv4fe_ram.sv
sv/ipv4fe_front.sv
sv/ipv4fe_queue.sv
sv/ipv4fe_back.sv
sv/ipv4_forward_engine_unit.sv
verif/ipv4_forward_engine_unit_tb.sv
